FILE: rtl/core/pats_pkg.sv
// shared types, constants and helpers for the priority aging task scheduler
`default_nettype none

package pats_pkg;

    localparam int SLOT_W = 4;

    typedef logic signed [5:0] t_stat;
    typedef logic signed [7:0] t_dyn;

    localparam t_dyn  CLAMP_LO  = -8'sd20;
    localparam t_dyn  CLAMP_HI  = 8'sd20;
    localparam t_stat STAT_LO   = -6'sd20;
    localparam t_stat STAT_HI   = 6'sd20;
    localparam t_dyn  DYN_FLOOR = 8'sh80;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_SET_PRIO = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_PICK     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_NEXT,
        CELL_WRITE,
        CELL_SET_STAT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      age;
    } t_cell_ctrl;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        t_stat             stat;
        t_dyn              dyn;
    } t_entry;

    function automatic t_stat clamp_prio(input t_dyn v);
        t_stat r;
        if (v < CLAMP_LO) begin
            r = STAT_LO;
        end else if (v > CLAMP_HI) begin
            r = STAT_HI;
        end else begin
            r = 6'(v);
        end
        return r;
    endfunction

    function automatic t_dyn widen_stat(input t_stat s);
        return {{2{s[5]}}, s};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pats_cell.sv
// one queue cell: holds an entry, takes its neighbour's entry or a broadcast write
`default_nettype none

module pats_cell
    import pats_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctrl        i_ctrl,
    input  wire t_entry            i_next,
    input  wire t_entry            i_wr,
    input  wire logic [SLOT_W-1:0] i_key,
    input  wire logic              i_after,
    output t_entry                 o_entry,
    output logic                   o_match,
    output logic                   o_after
);

    t_entry r_entry;
    t_entry n_entry;
    t_entry w_sel;

    always_comb begin
        w_sel = r_entry;
        case (i_ctrl.cmd)
            CELL_HOLD:      w_sel = r_entry;
            CELL_TAKE_NEXT: w_sel = i_next;
            CELL_WRITE:     w_sel = i_wr;
            CELL_SET_STAT:  w_sel.stat = i_wr.stat;
            default:        w_sel = r_entry;
        endcase
        n_entry = w_sel;
        if (i_ctrl.age && (w_sel.dyn != DYN_FLOOR)) begin
            n_entry.dyn = w_sel.dyn - 8'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_entry.valid && (r_entry.slot == i_key);
    assign o_after = i_after | o_match;

endmodule

`default_nettype wire

FILE: rtl/core/priority_aging_task_scheduler.sv
// top level: ready queue as a chain of cells, with the pick scan and output register
//
//  channel | direction | handshake                    | payload
//  in      | to block  | i_in_valid / o_in_stall      | i_opcode, i_task_slot, i_priority_value
//  out     | from block| o_out_valid / i_out_stall    | o_picked_task, o_picked_valid, o_op_error
//
// add, set priority, remove and a pick of an empty queue are done from IDLE, without a scan
// a pick rotates the whole chain once past the head cell in ST_SCAN,
// then ST_FINISH ages the others and moves the winner to the tail
// one transaction is in flight at a time; the output register frees the input side
// a stalled output blocks new input transactions; a pick is taken only with the output free
// synchronous active-low reset empties the queue
`default_nettype none

module priority_aging_task_scheduler
    import pats_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [SLOT_W-1:0] i_task_slot,
    input  wire logic signed [7:0] i_priority_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [SLOT_W-1:0]      o_picked_task,
    output logic                   o_picked_valid,
    output logic                   o_op_error
);

    localparam int IdxW = $clog2(MAX_TASKS);
    localparam int CntW = $clog2(MAX_TASKS + 1);

    t_state            r_state,     n_state;
    logic [IdxW-1:0]   r_step,      n_step;
    logic [CntW-1:0]   r_count,     n_count;
    logic              r_first_done, n_first_done;
    t_entry            r_best,      n_best;
    logic [IdxW-1:0]   r_best_pos,  n_best_pos;
    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_picked,    n_picked;
    logic              r_pvalid,    n_pvalid;
    logic              r_err,       n_err;

    t_entry            w_entry [MAX_TASKS];
    t_cell_ctrl        w_ctrl  [MAX_TASKS];
    logic [MAX_TASKS-1:0] w_match;
    logic [MAX_TASKS:0]   w_after;
    t_entry            w_wr;
    t_entry            w_wrap;
    t_entry            w_head;
    t_dyn              w_head_dyn;
    logic              w_can_load;
    logic              w_accept;
    logic              w_any_match;
    logic              w_full;
    t_opcode           w_op;

    assign w_after[0] = 1'b0;

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        t_entry w_next;
        if (g == MAX_TASKS - 1) begin : g_last
            assign w_next = w_wrap;
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end
        pats_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[g]),
            .i_next  (w_next),
            .i_wr    (w_wr),
            .i_key   (i_task_slot),
            .i_after (w_after[g]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g]),
            .o_after (w_after[g+1])
        );
    end

    assign w_can_load  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ST_IDLE) && w_can_load);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_any_match = |w_match;
    assign w_full      = (r_count == CntW'(MAX_TASKS));
    assign w_op        = t_opcode'(i_opcode);
    assign w_head      = w_entry[0];
    assign w_head_dyn  = ((r_step != '0) && !r_first_done) ? widen_stat(w_head.stat)
                                                           : w_head.dyn;

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_first_done = r_first_done;
        n_best       = r_best;
        n_best_pos   = r_best_pos;
        n_out_valid  = r_out_valid && i_out_stall;
        n_picked     = r_picked;
        n_pvalid     = r_pvalid;
        n_err        = r_err;
        w_wr         = '0;
        w_wrap       = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            w_ctrl[i] = '{cmd: CELL_HOLD, age: 1'b0};
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_picked    = '0;
                    n_pvalid    = 1'b0;
                    n_err       = 1'b0;
                    case (w_op)
                        OP_ADD: begin
                            if (w_full || w_any_match) begin
                                n_err = 1'b1;
                            end else begin
                                w_wr    = '{valid: 1'b1, slot: i_task_slot,
                                            stat: '0, dyn: '0};
                                n_count = r_count + 1'b1;
                                for (int i = 0; i < MAX_TASKS; i++) begin
                                    if (CntW'(i) == r_count) begin
                                        w_ctrl[i].cmd = CELL_WRITE;
                                    end
                                end
                            end
                        end
                        OP_SET_PRIO: begin
                            w_wr.stat = clamp_prio(i_priority_value);
                            for (int i = 0; i < MAX_TASKS; i++) begin
                                if (w_match[i]) begin
                                    w_ctrl[i].cmd = CELL_SET_STAT;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (!w_any_match) begin
                                n_err = 1'b1;
                            end else begin
                                n_count = r_count - 1'b1;
                                for (int i = 0; i < MAX_TASKS; i++) begin
                                    if (w_after[i+1]) begin
                                        w_ctrl[i].cmd = CELL_TAKE_NEXT;
                                    end
                                end
                            end
                        end
                        OP_PICK: begin
                            if (r_count != '0) begin
                                n_out_valid = r_out_valid && i_out_stall;
                                n_picked    = r_picked;
                                n_step      = '0;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                            n_err = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                w_wrap     = w_head;
                w_wrap.dyn = w_head_dyn;
                for (int i = 0; i < MAX_TASKS; i++) begin
                    w_ctrl[i].cmd = CELL_TAKE_NEXT;
                end
                if (w_head.valid && ((r_step == '0) || (w_head_dyn < r_best.dyn))) begin
                    n_best     = w_head;
                    n_best.dyn = w_head_dyn;
                    n_best_pos = r_step;
                end
                n_step = r_step + 1'b1;
                if (r_step == IdxW'(MAX_TASKS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_can_load) begin
                    w_wr     = '{valid: 1'b1, slot: r_best.slot, stat: r_best.stat,
                                 dyn: widen_stat(r_best.stat)};
                    for (int i = 0; i < MAX_TASKS; i++) begin
                        if (CntW'(i + 1) == r_count) begin
                            w_ctrl[i] = '{cmd: CELL_WRITE, age: 1'b0};
                        end else if (CntW'(i) < r_count) begin
                            if (IdxW'(i) >= r_best_pos) begin
                                w_ctrl[i] = '{cmd: CELL_TAKE_NEXT, age: 1'b1};
                            end else begin
                                w_ctrl[i] = '{cmd: CELL_HOLD, age: 1'b1};
                            end
                        end
                    end
                    n_first_done = 1'b1;
                    n_out_valid  = 1'b1;
                    n_picked     = r_best.slot;
                    n_pvalid     = 1'b1;
                    n_err        = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= '0;
            r_count      <= '0;
            r_first_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_count      <= n_count;
            r_first_done <= n_first_done;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best     <= n_best;
        r_best_pos <= n_best_pos;
        r_picked   <= n_picked;
        r_pvalid   <= n_pvalid;
        r_err      <= n_err;
    end

    assign o_out_valid    = r_out_valid;
    assign o_picked_task  = r_picked;
    assign o_picked_valid = r_pvalid;
    assign o_op_error     = r_err;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_TASKS))
        else $error("queue count beyond capacity");

    a_head_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (w_entry[0].valid == (r_count != '0)))
        else $error("head cell occupancy disagrees with count");

    a_full_rotation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && $past(r_state) == ST_SCAN)
            |-> ($past(r_step) == IdxW'(MAX_TASKS - 1)))
        else $error("scan left before a full rotation");

    a_pick_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_picked_valid) |-> !o_op_error)
        else $error("successful pick flagged as error");
`endif

endmodule

`default_nettype wire
